### rtl/rhc_pkg.sv
// Shared types and constants for the RGB to HSV converter.
package rhc_pkg;
  localparam int unsigned HUE_TURN = 5760;
  localparam int unsigned HUE_SECT = 960;
  localparam int unsigned PCT_FIX = 25600;
  localparam int unsigned QW = 16;
  localparam int unsigned NH = 22;
  localparam int unsigned NS = 23;

  typedef struct packed {
    logic           vld;
    logic [NH-1:0]  hrem;
    logic [12:0]    hq;
    logic [NS-1:0]  srem;
    logic [QW-1:0]  sq;
    logic [8:0]     hden;
    logic [7:0]     sden;
    logic [14:0]    val;
    logic [7:0]     alpha;
  } lane_t;
endpackage

### rtl/rhc_cell.sv
// One restoring-division step for hue and saturation quotients.
module rhc_cell #(
  parameter int unsigned SHIFT = 0
) (
  input  logic            clk,
  input  logic            rst,
  input  rhc_pkg::lane_t  din,
  output rhc_pkg::lane_t  dout
);
  rhc_pkg::lane_t nxt;
  logic [rhc_pkg::NH+8:0] ht;
  logic [rhc_pkg::NS+7:0] st;

  always_comb begin
    nxt = din;
    ht = {9'd0, din.hrem} - ({{rhc_pkg::NH{1'b0}}, din.hden} << SHIFT);
    st = {8'd0, din.srem} - ({23'd0, din.sden} << SHIFT);
    if (!ht[rhc_pkg::NH+8] && SHIFT < 13) begin
      nxt.hrem = ht[rhc_pkg::NH-1:0];
      nxt.hq = din.hq | (13'd1 << SHIFT);
    end
    if (!st[rhc_pkg::NS+7] && din.sden != 8'd0) begin
      nxt.srem = st[rhc_pkg::NS-1:0];
      nxt.sq = din.sq | (16'd1 << SHIFT);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) dout.vld <= 1'b0;
    else dout.vld <= din.vld;
    dout.hrem <= nxt.hrem; dout.hq <= nxt.hq; dout.srem <= nxt.srem;
    dout.sq <= nxt.sq; dout.hden <= nxt.hden; dout.sden <= nxt.sden;
    dout.val <= nxt.val; dout.alpha <= nxt.alpha;
  end
endmodule

### rtl/rgb_to_hsv_converter.sv
// Top level of the pipelined RGB to HSV converter.
// The converter accepts one pixel transfer in every clock cycle; busy is
// always low. A first register stage finds max, min and the rounded hue
// numerator, then a row of sixteen division cells resolves one saturation
// quotient bit each and, in the cells for the low 13 bits, one hue quotient
// bit each, and a final stage wraps the hue. Each result appears on the
// outputs with done high for exactly one cycle. The receiver cannot stall the
// converter, so results must be taken as they arrive.
module rgb_to_hsv_converter (
  input  logic        clk,
  input  logic        rst,
  input  logic        start,
  output logic        busy,
  input  logic [7:0]  red,
  input  logic [7:0]  green,
  input  logic [7:0]  blue,
  input  logic [7:0]  alpha,
  output logic        done,
  output logic [12:0] hue,
  output logic [14:0] saturation,
  output logic [14:0] brightness,
  output logic [7:0]  opacity
);
  localparam int unsigned NC = rhc_pkg::QW;

  rhc_pkg::lane_t head;
  rhc_pkg::lane_t lane [NC+1];
  logic [7:0] mx, mn, dif;
  logic signed [11:0] sec;
  logic [rhc_pkg::NH-1:0] num;
  logic [14:0] vprod;
  logic signed [22:0] snum;

  assign busy = 1'b0;

  always_comb begin
    mx = red; mn = red;
    if (green > mx) mx = green;
    if (blue > mx) mx = blue;
    if (green < mn) mn = green;
    if (blue < mn) mn = blue;
    dif = mx - mn;
    // Sector numerator: blue wins ties over green, green over red.
    if (mx == blue) sec = 12'sd4 * $signed({4'd0, dif}) + $signed({4'd0, red})
                         - $signed({4'd0, green});
    else if (mx == green) sec = 12'sd2 * $signed({4'd0, dif})
                         + $signed({4'd0, blue}) - $signed({4'd0, red});
    else sec = $signed({4'd0, green}) - $signed({4'd0, blue});
    snum = 23'sd960 * 23'(sec);
    if (snum < 0) snum = snum + $signed(23'(rhc_pkg::HUE_TURN) * {15'd0, dif});
    // Rounded division: (2*num + diff) / (2*diff).
    num = rhc_pkg::NH'({snum[21:0], 1'b0} + {14'd0, dif});
    vprod = 15'(mx) * 15'd100;
  end

  always_ff @(posedge clk) begin
    if (rst) head.vld <= 1'b0;
    else head.vld <= start;
    head.hrem <= num;
    head.hq <= '0;
    head.srem <= 23'(dif) * 23'(rhc_pkg::PCT_FIX);
    head.sq <= '0;
    head.hden <= (dif == 8'd0) ? 9'd0 : {dif, 1'b0};
    head.sden <= (dif == 8'd0) ? 8'd0 : mx;
    // max*25600/255 = max*100 + floor(max*100/255). For x up to 25500,
    // floor(x/255) = (x + (x>>8) + 1) >> 8 exactly.
    head.val <= vprod + 15'((16'(vprod) + 16'(vprod >> 8) + 16'd1) >> 8);
    head.alpha <= alpha;
  end

  assign lane[0] = head;
  for (genvar i = 0; i < NC; i++) begin : g_cell
    rhc_cell #(.SHIFT(NC-1-i)) u_cell (.clk(clk), .rst(rst), .din(lane[i]),
                                       .dout(lane[i+1]));
  end

  always_ff @(posedge clk) begin
    if (rst) done <= 1'b0;
    else done <= lane[NC].vld;
    if (lane[NC].hden == 9'd0) hue <= '0;
    else if (lane[NC].hq >= 13'(rhc_pkg::HUE_TURN))
      hue <= lane[NC].hq - 13'(rhc_pkg::HUE_TURN);
    else hue <= lane[NC].hq;
    saturation <= lane[NC].sq[14:0];
    brightness <= lane[NC].val;
    opacity <= lane[NC].alpha;
  end
endmodule

### dv/tb.sv
// Self-checking testbench for the RGB to HSV converter.
module tb;
  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        start = 1'b0;
  logic        busy;
  logic [7:0]  red = '0, green = '0, blue = '0, alpha = '0;
  logic        done;
  logic [12:0] hue;
  logic [14:0] saturation, brightness;
  logic [7:0]  opacity;

  typedef struct packed {
    logic [12:0] hue;
    logic [14:0] sat;
    logic [14:0] bright;
    logic [7:0]  opac;
  } hsv_t;

  typedef struct {
    logic [7:0] r, g, b, a;
    logic       typed;  // expected value below is written in the table
    hsv_t       hsv;
  } pixel_row_t;

  hsv_t pending_hsv[$];
  int   mismatches = 0;

  rgb_to_hsv_converter u_top (
    .clk(clk), .rst(rst), .start(start), .busy(busy),
    .red(red), .green(green), .blue(blue), .alpha(alpha),
    .done(done), .hue(hue), .saturation(saturation),
    .brightness(brightness), .opacity(opacity)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Exact integer conversion of one pixel, with blue winning ties over green
  // and green over red.
  function automatic hsv_t convert_pixel(logic [7:0] r, logic [7:0] g,
                                         logic [7:0] b, logic [7:0] a);
    int   mx, mn, diff, sector, n, num, h;
    hsv_t res;
    mx = r; mn = r;
    if (g > mx) mx = g;
    if (b > mx) mx = b;
    if (g < mn) mn = g;
    if (b < mn) mn = b;
    diff = mx - mn;
    res = '0;
    if (diff != 0) begin
      if (mx == b) begin
        sector = 4; n = int'(r) - int'(g);
      end else if (mx == g) begin
        sector = 2; n = int'(b) - int'(r);
      end else begin
        sector = 0; n = int'(g) - int'(b);
      end
      num = rhc_pkg::HUE_SECT * (sector * diff + n);
      if (num < 0) num += rhc_pkg::HUE_TURN * diff;
      h = (2 * num + diff) / (2 * diff);
      if (h >= rhc_pkg::HUE_TURN) h -= rhc_pkg::HUE_TURN;
      res.hue = h[12:0];
      res.sat = 15'((diff * rhc_pkg::PCT_FIX) / mx);
    end
    res.bright = 15'((mx * rhc_pkg::PCT_FIX) / 255);
    res.opac = a;
    return res;
  endfunction

  task automatic report_mismatch(string what, int got, int want);
    $display("mismatch %s: got %0d expected %0d", what, got, want);
    mismatches++;
  endtask

  // Every result is compared with the oldest pending expectation.
  always @(posedge clk) begin
    hsv_t want;
    if (!rst && done) begin
      if (pending_hsv.size() == 0) begin
        report_mismatch("unexpected result, pending", 0, 0);
      end else begin
        want = pending_hsv.pop_front();
        if (hue != want.hue) report_mismatch("hue", hue, want.hue);
        if (saturation != want.sat) report_mismatch("saturation", saturation, want.sat);
        if (brightness != want.bright)
          report_mismatch("brightness", brightness, want.bright);
        if (opacity != want.opac) report_mismatch("opacity", opacity, want.opac);
      end
    end
  end

  // Hold one pixel on the ports until a transfer happens.
  task automatic send_pixel(logic [7:0] r, logic [7:0] g, logic [7:0] b,
                            logic [7:0] a, logic typed, hsv_t hsv);
    start <= 1'b1;
    red <= r; green <= g; blue <= b; alpha <= a;
    do @(posedge clk); while (busy);
    pending_hsv.push_back(typed ? hsv : convert_pixel(r, g, b, a));
  endtask

  task automatic idle_cycles(int n);
    start <= 1'b0;
    repeat (n) @(posedge clk);
  endtask

  pixel_row_t pixel_table[] = '{
    '{8'd0,   8'd0,   8'd0,   8'd0,   1'b1, '{13'd0,    15'd0,     15'd0,     8'd0}},
    '{8'd255, 8'd255, 8'd255, 8'd255, 1'b1, '{13'd0,    15'd0,     15'd25600, 8'd255}},
    '{8'd255, 8'd0,   8'd0,   8'd170, 1'b1, '{13'd0,    15'd25600, 15'd25600, 8'd170}},
    '{8'd0,   8'd255, 8'd0,   8'd85,  1'b1, '{13'd1920, 15'd25600, 15'd25600, 8'd85}},
    '{8'd0,   8'd0,   8'd255, 8'd1,   1'b1, '{13'd3840, 15'd25600, 15'd25600, 8'd1}},
    '{8'd128, 8'd128, 8'd128, 8'd128, 1'b0, '0},
    '{8'd255, 8'd255, 8'd0,   8'd7,   1'b0, '0},
    '{8'd0,   8'd255, 8'd255, 8'd9,   1'b0, '0},
    '{8'd255, 8'd0,   8'd255, 8'd2,   1'b0, '0},
    '{8'd255, 8'd0,   8'd1,   8'd3,   1'b0, '0},
    '{8'd255, 8'd1,   8'd0,   8'd4,   1'b0, '0},
    '{8'd1,   8'd0,   8'd0,   8'd5,   1'b0, '0},
    '{8'd0,   8'd0,   8'd1,   8'd6,   1'b0, '0},
    '{8'd254, 8'd0,   8'd255, 8'd8,   1'b0, '0},
    '{8'd255, 8'd254, 8'd254, 8'd10,  1'b0, '0},
    '{8'd200, 8'd100, 8'd150, 8'd11,  1'b0, '0},
    '{8'd10,  8'd250, 8'd100, 8'd12,  1'b0, '0},
    '{8'd90,  8'd3,   8'd240, 8'd13,  1'b0, '0},
    '{8'd255, 8'd254, 8'd255, 8'd14,  1'b0, '0}
  };

  initial begin
    int n, wait_cycles;
    repeat (2) @(posedge clk);
    rst <= 1'b0;
    foreach (pixel_table[i])
      send_pixel(pixel_table[i].r, pixel_table[i].g, pixel_table[i].b,
                 pixel_table[i].a, pixel_table[i].typed, pixel_table[i].hsv);
    for (n = 0; n < 1850; n++) begin
      // Bursts of idle cycles, none in the final stretch.
      if (n < 1600 && $urandom_range(0, 7) == 0) idle_cycles($urandom_range(1, 11));
      if ($urandom_range(0, 9) == 0)
        send_pixel(8'($urandom_range(0, 3)) * 8'd85, 8'($urandom_range(0, 3)) * 8'd85,
                   8'($urandom_range(0, 3)) * 8'd85, 8'($urandom), 1'b0, '0);
      else
        send_pixel(8'($urandom), 8'($urandom), 8'($urandom), 8'($urandom), 1'b0, '0);
    end
    start <= 1'b0;
    wait_cycles = 0;
    while (pending_hsv.size() != 0 && wait_cycles < 1000) begin
      @(posedge clk);
      wait_cycles++;
    end
    repeat (25) @(posedge clk);
    if (mismatches == 0 && pending_hsv.size() == 0) $display("tb passed");
    else $display("tb failed");
    $finish;
  end

  initial begin
    #2000000;
    $display("tb failed");
    $finish;
  end
endmodule
